// ----- sv/sha_pkg.sv -----
// SHA-256 hasher package: payload structs, round constants, command/status types.
// Used by all modules of the sha256_stream_hasher block. No dependencies.
`timescale 1ns / 1ps
package sha_pkg;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       has_byte;
      logic       is_last;
   } req_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic       wr_byte;     // write byte into buffer at fill
      logic [7:0] wr_data;
      logic       clr_len;     // reset lengths and hash to IV
      logic       load_pad;    // write padding byte (zero or 0x80) at fill
      logic       pad_mark;
      logic       load_len;    // write length into bytes 56..63
      logic       start;       // load W and working vars
      logic       round;       // one compression round
      logic       finish;      // hash += working vars
      logic [5:0] rnd;
      logic [2:0] out_sel;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic [5:0] fill;
   } sts_type;

   localparam logic [7:0] PAD_MARK = 8'h80;
   localparam logic [5:0] LEN_POS = 6'd56;

   localparam logic [31:0] INIT_HASH [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

   localparam logic [31:0] ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

   function automatic logic [31:0] ror32(input logic [31:0] v, input int n);
      ror32 = (v >> n) | (v << (32 - n));
   endfunction

endpackage

// ----- sv/sha256_stream_hasher_top.sv -----
// Top level of the SHA-256 byte-stream hasher.
// Depends on sha_pkg, sha_ctrl and sha_datapath.
`timescale 1ns / 1ps
// Takes one byte per transfer; a byte that fills a 64-byte block stalls the input
// while the single shared round unit runs 64 rounds (one per cycle) plus load
// and hash update. A last transfer pads one byte per cycle up to the length field,
// runs one or two compressions, then presents the digest as eight result transfers,
// word 0 first, and returns to the initial hash for the next message.
module sha256_stream_hasher_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  sha_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output sha_pkg::rsp_type rsp_data
);
   import sha_pkg::*;

   cmd_type     cmd;
   sts_type     sts;
   logic [31:0] hash_word;

   sha_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .hash_word(hash_word), .sts(sts), .cmd(cmd)
   );

   sha_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts), .hash_word(hash_word)
   );

endmodule

// ----- sv/sha_datapath.sv -----
// SHA-256 datapath: block buffer, length counter, schedule window, round logic, hash words.
// Depends on sha_pkg.
`timescale 1ns / 1ps
module sha_datapath (
   input  logic             clock,
   input  logic             reset,
   input  sha_pkg::cmd_type cmd,
   output sha_pkg::sts_type sts,
   output logic [31:0]      hash_word
);
   import sha_pkg::*;

   // block held as 16 big-endian words; byte k sits in word k/4, lane k%4 from the top
   logic [31:0] blk_ff [16];
   logic [5:0]  fill_ff, fill_in;
   logic [63:0] len_ff, len_in;
   logic [31:0] w_ff [16];
   logic [31:0] v_ff [8];
   logic [31:0] h_ff [8];
   logic [63:0] bits;
   logic [31:0] w_new, wt, t1, t2, x15, x2, s0, s1;
   logic [31:0] a, b, c, d, e, f, g, h;

   assign bits = {len_ff[60:0], 3'b000};
   assign sts.fill = fill_ff;
   assign hash_word = h_ff[cmd.out_sel];

   assign a = v_ff[0]; assign b = v_ff[1]; assign c = v_ff[2]; assign d = v_ff[3];
   assign e = v_ff[4]; assign f = v_ff[5]; assign g = v_ff[6]; assign h = v_ff[7];

   // window is a shift line: w_ff[0] is W[t-16]
   assign x15 = w_ff[1];
   assign x2  = w_ff[14];
   assign s0 = ror32(x15, 7) ^ ror32(x15, 18) ^ (x15 >> 3);
   assign s1 = ror32(x2, 17) ^ ror32(x2, 19) ^ (x2 >> 10);
   assign w_new = w_ff[0] + s0 + w_ff[9] + s1;
   assign wt = (cmd.rnd < 6'd16) ? w_ff[cmd.rnd[3:0]] : w_new;
   assign t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
      + ROUND_K[cmd.rnd] + wt;
   assign t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));

   always_comb begin
      fill_in = fill_ff;
      len_in = len_ff;
      if (cmd.clr_len) begin
         fill_in = '0;
         len_in = '0;
      end else if (cmd.wr_byte) begin
         fill_in = fill_ff + 6'd1;
         len_in = len_ff + 64'd1;
      end else if (cmd.load_pad) begin
         fill_in = fill_ff + 6'd1;
      end else if (cmd.load_len) begin
         fill_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         len_ff <= '0;
      end else begin
         fill_ff <= fill_in;
         len_ff <= len_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_byte) begin
         blk_ff[fill_ff[5:2]][{~fill_ff[1:0], 3'b000} +: 8] <= cmd.wr_data;
      end else if (cmd.load_pad) begin
         blk_ff[fill_ff[5:2]][{~fill_ff[1:0], 3'b000} +: 8] <=
            cmd.pad_mark ? PAD_MARK : 8'h00;
      end else if (cmd.load_len) begin
         blk_ff[14] <= bits[63:32];
         blk_ff[15] <= bits[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         for (int i = 0; i < 16; i++)
            w_ff[i] <= blk_ff[i];
         for (int i = 0; i < 8; i++)
            v_ff[i] <= h_ff[i];
      end else if (cmd.round) begin
         if (cmd.rnd >= 6'd16) begin
            for (int i = 0; i < 15; i++)
               w_ff[i] <= w_ff[i+1];
            w_ff[15] <= w_new;
         end
         v_ff[7] <= g; v_ff[6] <= f; v_ff[5] <= e; v_ff[4] <= d + t1;
         v_ff[3] <= c; v_ff[2] <= b; v_ff[1] <= a; v_ff[0] <= t1 + t2;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clr_len) begin
         for (int i = 0; i < 8; i++)
            h_ff[i] <= INIT_HASH[i];
      end else if (cmd.finish) begin
         for (int i = 0; i < 8; i++)
            h_ff[i] <= h_ff[i] + v_ff[i];
      end
   end

endmodule

// ----- sv/sha_ctrl.sv -----
// SHA-256 controller: sequences byte intake, padding, compressions and digest output.
// Depends on sha_pkg.
`timescale 1ns / 1ps
module sha_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  sha_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output sha_pkg::rsp_type rsp_data,
   input  logic [31:0]      hash_word,
   input  sha_pkg::sts_type sts,
   output sha_pkg::cmd_type cmd
);
   import sha_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_START = 3'd1;
   localparam logic [2:0] ST_ROUND = 3'd2;
   localparam logic [2:0] ST_FIN   = 3'd3;
   localparam logic [2:0] ST_PAD   = 3'd4;
   localparam logic [2:0] ST_OUT   = 3'd5;

   logic [2:0] state_ff, state_in;
   logic [5:0] rnd_ff, rnd_in;
   logic       last_ff, last_in;     // message ending: pad after this compression
   logic       mark_ff, mark_in;     // 0x80 still to write
   logic [2:0] idx_ff, idx_in;
   logic       take;

   assign req_stall = (state_ff != ST_IDLE);
   assign take = req_valid && !req_stall;
   assign rsp_valid = (state_ff == ST_OUT);
   assign rsp_data.digest_word = hash_word;
   assign rsp_data.word_index = idx_ff;
   assign rsp_data.last_word = (idx_ff == 3'd7);

   always_comb begin
      state_in = state_ff;
      rnd_in = rnd_ff;
      last_in = last_ff;
      mark_in = mark_ff;
      idx_in = idx_ff;
      cmd = '0;
      cmd.wr_data = req_data.data_byte;
      cmd.rnd = rnd_ff;
      cmd.out_sel = idx_ff;
      cmd.pad_mark = mark_ff;
      case (state_ff)
         ST_IDLE: begin
            if (take) begin
               last_in = req_data.is_last;
               mark_in = 1'b1;
               if (req_data.has_byte) begin
                  cmd.wr_byte = 1'b1;
                  if (sts.fill == 6'd63)
                     state_in = ST_START;
                  else if (req_data.is_last)
                     state_in = ST_PAD;
               end else if (req_data.is_last) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_START: begin
            cmd.start = 1'b1;
            rnd_in = '0;
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            cmd.round = 1'b1;
            rnd_in = rnd_ff + 6'd1;
            if (rnd_ff == 6'd63)
               state_in = ST_FIN;
         end
         ST_FIN: begin
            cmd.finish = 1'b1;
            idx_in = '0;
            if (!last_ff)
               state_in = ST_IDLE;
            else if (mark_ff)
               state_in = ST_PAD;
            else
               state_in = ST_OUT;
         end
         ST_PAD: begin
            // one byte a cycle: 0x80, zeros, then length once fill reaches 56
            if (!mark_ff && sts.fill == LEN_POS) begin
               cmd.load_len = 1'b1;
               mark_in = 1'b0;
               state_in = ST_START;
            end else begin
               cmd.load_pad = 1'b1;
               mark_in = 1'b0;
               if (sts.fill == 6'd63)
                  state_in = ST_START;
            end
         end
         ST_OUT: begin
            if (!rsp_stall) begin
               idx_in = idx_ff + 3'd1;
               if (idx_ff == 3'd7) begin
                  cmd.clr_len = 1'b1;
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // after a padding block compresses (fill wrapped to 0, mark gone), FIN goes back to PAD
   // to write zeros and length; after the length block, mark is clear and fill is 0 only then
   // if length was loaded, so track that with the state path below.
   logic lenblk_ff, lenblk_in;
   always_comb begin
      lenblk_in = lenblk_ff;
      if (cmd.load_len) lenblk_in = 1'b1;
      if (state_ff == ST_IDLE) lenblk_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rnd_ff <= '0;
         last_ff <= 1'b0;
         mark_ff <= 1'b0;
         idx_ff <= '0;
         lenblk_ff <= 1'b0;
      end else begin
         state_ff <= (state_ff == ST_FIN && last_ff && !mark_ff && !lenblk_ff)
            ? ST_PAD : state_in;
         rnd_ff <= rnd_in;
         last_ff <= last_in;
         mark_ff <= mark_in;
         idx_ff <= idx_in;
         lenblk_ff <= lenblk_in;
      end
   end

endmodule

// ----- bench/sha256_stream_hasher_checker.sv -----
// Checker for the SHA-256 stream hasher: watches both channels, predicts the
// digest words of each message and compares them. Depends on sha_pkg.
`timescale 1ns / 1ps
module sha256_stream_hasher_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  sha_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  sha_pkg::rsp_type rsp_data,
   output int               fail_count,
   output int               words_pending
);
   import sha_pkg::*;

   logic [31:0] hash_state [8];
   logic [7:0]  block_bytes [64];
   int          block_fill;
   logic [63:0] byte_count;
   rsp_type     digest_queue [$];

   assign words_pending = digest_queue.size();

   function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
      return (v >> n) | (v << (32 - n));
   endfunction

   task automatic compress();
      logic [31:0] w [64];
      logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
      for (int i = 0; i < 16; i++)
         w[i] = {block_bytes[4*i], block_bytes[4*i+1], block_bytes[4*i+2], block_bytes[4*i+3]};
      for (int i = 16; i < 64; i++) begin
         s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
         s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
         w[i] = w[i-16] + s0 + w[i-7] + s1;
      end
      a = hash_state[0]; b = hash_state[1]; c = hash_state[2]; d = hash_state[3];
      e = hash_state[4]; f = hash_state[5]; g = hash_state[6]; h = hash_state[7];
      for (int t = 0; t < 64; t++) begin
         t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
            + ROUND_K[t] + w[t];
         t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
         h = g; g = f; f = e; e = d + t1;
         d = c; c = b; b = a; a = t1 + t2;
      end
      hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
      hash_state[4] += e; hash_state[5] += f; hash_state[6] += g; hash_state[7] += h;
   endtask

   task automatic absorb_transfer(input req_type item);
      logic [63:0] bit_len;
      rsp_type     word;
      if (item.has_byte) begin
         block_bytes[block_fill] = item.data_byte;
         block_fill++;
         byte_count++;
         if (block_fill == 64) begin
            compress();
            block_fill = 0;
         end
      end
      if (!item.is_last) return;
      bit_len = byte_count << 3;
      block_bytes[block_fill] = PAD_MARK;
      block_fill++;
      if (block_fill > LEN_POS) begin
         for (int i = block_fill; i < 64; i++) block_bytes[i] = 8'h00;
         compress();
         block_fill = 0;
      end
      for (int i = block_fill; i < LEN_POS; i++) block_bytes[i] = 8'h00;
      for (int i = 0; i < 8; i++) block_bytes[63 - i] = bit_len[8*i +: 8];
      compress();
      for (int i = 0; i < 8; i++) begin
         word.digest_word = hash_state[i];
         word.word_index = 3'(i);
         word.last_word = (i == 7);
         digest_queue.push_back(word);
      end
      hash_state = INIT_HASH;
      block_fill = 0;
      byte_count = '0;
   endtask

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      fail_count++;
   endtask

   always @(posedge clock) begin
      rsp_type exp_word;
      if (reset) begin
         fail_count = 0;
         hash_state = INIT_HASH;
         block_fill = 0;
         byte_count = '0;
         digest_queue.delete();
      end else begin
         if (req_valid && !req_stall) absorb_transfer(req_data);
         if (rsp_valid && !rsp_stall) begin
            if (digest_queue.size() == 0) begin
               report_mismatch($sformatf("unexpected word %h", rsp_data));
            end else begin
               exp_word = digest_queue.pop_front();
               if (rsp_data.digest_word !== exp_word.digest_word)
                  report_mismatch($sformatf("digest_word %h, expected %h",
                     rsp_data.digest_word, exp_word.digest_word));
               if (rsp_data.word_index !== exp_word.word_index)
                  report_mismatch($sformatf("word_index %0d, expected %0d",
                     rsp_data.word_index, exp_word.word_index));
               if (rsp_data.last_word !== exp_word.last_word)
                  report_mismatch($sformatf("last_word %b, expected %b",
                     rsp_data.last_word, exp_word.last_word));
            end
         end
      end
   end
endmodule

// ----- bench/sha256_stream_hasher_top_test.sv -----
// Testbench top for the SHA-256 stream hasher: drives message bytes with random
// gaps and stalls; the checker module predicts and compares. Depends on sha_pkg.
`timescale 1ns / 1ps
module sha256_stream_hasher_top_test;
   import sha_pkg::*;

   localparam int CYCLE_LIMIT = 400000;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;
   int      fail_count;
   int      words_pending;
   int      cycle_count;
   int      item_count;

   sha256_stream_hasher_top i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   sha256_stream_hasher_checker i_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .fail_count(fail_count), .words_pending(words_pending)
   );

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   function automatic int gap_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // receiver stall: random on each cycle outside periodic stall-free windows
   always @(posedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else if (cycle_count % 500 < 150) rsp_stall <= 1'b0;
      else rsp_stall <= (gap_length() > 0);
   end

   always @(posedge clock) begin
      if (reset) begin
         cycle_count <= 0;
      end else begin
         cycle_count <= cycle_count + 1;
         if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL sha256_stream_hasher_top");
            $finish;
         end
      end
   end

   // one transfer, with an optional idle gap first
   task automatic send(input logic [7:0] data_val, input logic has_val, input logic last_val,
                       input bit gaps);
      int idle;
      idle = gaps ? gap_length() : 0;
      repeat (idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{data_byte: data_val, has_byte: has_val, is_last: last_val};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      item_count++;
   endtask

   task automatic send_message(input int len, input bit byte_on_last, input bit gaps);
      int body;
      body = (byte_on_last && len > 0) ? len - 1 : len;
      for (int i = 0; i < body; i++) begin
         if ($urandom_range(0, 15) == 0) send(8'($urandom), 1'b0, 1'b0, gaps);
         send(8'($urandom), 1'b1, 1'b0, gaps);
      end
      if (byte_on_last && len > 0) send(8'($urandom), 1'b1, 1'b1, gaps);
      else send(8'($urandom), 1'b0, 1'b1, gaps);
   endtask

   initial begin
      int len;
      item_count = 0;
      req_valid = 1'b0;
      req_data = '0;
      reset = 1'b1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed: empty message, idle items, byte extremes, last with byte
      send(8'hff, 1'b0, 1'b1, 0);
      send(8'hff, 1'b0, 1'b0, 0);
      send(8'h00, 1'b1, 1'b0, 0);
      send(8'hff, 1'b1, 1'b1, 0);
      send(8'haa, 1'b1, 1'b0, 0);
      send(8'h55, 1'b0, 1'b1, 0);
      send(8'h61, 1'b1, 1'b1, 0);
      send(8'h00, 1'b1, 1'b1, 0);
      // random messages; lengths around block and length-field boundaries, plus short ones
      while (item_count < 170) begin
         case ($urandom_range(0, 5))
            0: len = $urandom_range(54, 57);
            1: len = $urandom_range(63, 65);
            2: len = $urandom_range(118, 121);
            default: len = $urandom_range(0, 12);
         endcase
         send_message(len, $urandom_range(0, 1), $urandom_range(0, 3) != 0);
      end
      req_valid <= 1'b0;
      while (words_pending != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (fail_count == 0) $display("PASS sha256_stream_hasher_top");
      else $display("FAIL sha256_stream_hasher_top");
      $finish;
   end
endmodule

// ----- files.f -----
sv/sha_pkg.sv
sv/sha_datapath.sv
sv/sha_ctrl.sv
sv/sha256_stream_hasher_top.sv
bench/sha256_stream_hasher_checker.sv
bench/sha256_stream_hasher_top_test.sv
